// ===== src/mts_pkg.sv =====
// Shared types and constants of the mail transmit dot stuffer.
// Used by the front, queue, back and top level modules; depends on nothing.
package mts_pkg;

    // Default widths of the byte and line counters.
    localparam int MTS_SIZE_BITS = 32;
    localparam int MTS_LINE_BITS = 16;

    // Widths of the configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_XFER_MODE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_LINES   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MSG_SIZE    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NO_FINAL_LF = 2'd3;

    // Request type codes.
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_DATA   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // Characters of the transmit stream.
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Output slots of one request, sent in ascending order.
    localparam int unsigned SLOT_ABORT = 0;
    localparam int unsigned SLOT_DOT   = 1;
    localparam int unsigned SLOT_BYTE  = 2;
    localparam int unsigned SLOT_CR_A  = 3;
    localparam int unsigned SLOT_LF_A  = 4;
    localparam int unsigned SLOT_CR_B  = 5;
    localparam int unsigned SLOT_LF_B  = 6;
    localparam int unsigned SLOT_TDOT  = 7;
    localparam int unsigned SLOT_TCR   = 8;
    localparam int unsigned SLOT_TLF   = 9;
    localparam int unsigned SLOT_COUNT = 10;

    // Depth of the command queue; a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef logic [SLOT_COUNT-1:0] slot_mask_t;

    // One classified request: which slots to send and the data byte.
    typedef struct packed {
        slot_mask_t  mask;
        logic [7:0]  data;
    } mts_cmd_t;

    // Write side of the command queue.
    typedef struct packed {
        logic      push;
        mts_cmd_t  cmd;
    } mts_push_t;

    // Read side of the command queue.
    typedef struct packed {
        logic      valid;
        mts_cmd_t  cmd;
    } mts_head_t;

    // Transfer phase.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_WHOLE  = 4'b0010,
        PH_HEADER = 4'b0100,
        PH_BODY   = 4'b1000
    } phase_t;

endpackage

// ===== src/mts_front.sv =====
// Front part: configuration registers, transfer state and request classification.
// Turns each accepted request into a slot mask for the queue; uses mts_pkg.
module mts_front #(
    parameter int SIZE_BITS = mts_pkg::MTS_SIZE_BITS,
    parameter int LINE_BITS = mts_pkg::MTS_LINE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mts_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mts_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                accept,
    input  logic [1:0]                          req_type,
    input  logic [7:0]                          data_byte,
    output mts_pkg::mts_push_t                  push
);
    import mts_pkg::*;

    localparam logic [SIZE_BITS-1:0] SIZE_ONE = SIZE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    logic        xfer_mode_reg;
    logic [15:0] top_lines_reg;
    logic [31:0] msg_size_reg;
    logic        no_final_lf_reg;

    logic                 at_line_start_reg, at_line_start_next;
    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [LINE_BITS-1:0] lines_left_reg, lines_left_next;
    logic                 aborted_reg, aborted_next;

    logic [63:0]          size_wide;
    logic [31:0]          lines_wide;
    logic [SIZE_BITS-1:0] size_load;
    logic [LINE_BITS-1:0] lines_load;
    slot_mask_t           mask;
    slot_mask_t           stuff_mask;
    logic                 stuff_line_start;

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xfer_mode_reg   <= 1'b0;
            top_lines_reg   <= 16'd0;
            msg_size_reg    <= 32'd0;
            no_final_lf_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_XFER_MODE:   xfer_mode_reg   <= cfg_wdata[0];
                REG_TOP_LINES:   top_lines_reg   <= cfg_wdata[15:0];
                REG_MSG_SIZE:    msg_size_reg    <= cfg_wdata;
                REG_NO_FINAL_LF: no_final_lf_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Start values of the counters, fitted to their widths; the size drops by one without final LF.
    always_comb begin
        size_wide  = {32'd0, msg_size_reg};
        lines_wide = {16'd0, top_lines_reg};
        size_load  = size_wide[SIZE_BITS-1:0];
        lines_load = lines_wide[LINE_BITS-1:0];
        if (no_final_lf_reg && (size_load != '0)) begin
            size_load = size_load - SIZE_ONE;
        end
    end

    // Dot stuffing and LF expansion of the incoming byte.
    always_comb begin
        stuff_mask       = '0;
        stuff_line_start = 1'b0;
        if (at_line_start_reg && (data_byte == CH_DOT)) begin
            stuff_mask[SLOT_DOT] = 1'b1;
        end
        if (data_byte == CH_LF) begin
            stuff_mask[SLOT_CR_A] = 1'b1;
            stuff_mask[SLOT_LF_A] = 1'b1;
            stuff_line_start      = 1'b1;
        end else begin
            stuff_mask[SLOT_BYTE] = 1'b1;
        end
    end

    // Transfer state update and classification of one request.
    always_comb begin
        at_line_start_next = at_line_start_reg;
        phase_next         = phase_reg;
        bytes_left_next    = bytes_left_reg;
        lines_left_next    = lines_left_reg;
        aborted_next       = aborted_reg;
        mask               = '0;
        case (req_type)
            REQ_START: begin
                bytes_left_next    = size_load;
                lines_left_next    = lines_load;
                at_line_start_next = 1'b1;
                aborted_next       = 1'b0;
                phase_next         = xfer_mode_reg ? PH_HEADER : PH_WHOLE;
            end
            REQ_DATA: begin
                if (!aborted_reg) begin
                    case (phase_reg)
                        PH_WHOLE: begin
                            if (bytes_left_reg == '0) begin
                                aborted_next     = 1'b1;
                                mask[SLOT_ABORT] = 1'b1;
                            end else begin
                                bytes_left_next    = bytes_left_reg - SIZE_ONE;
                                mask               = stuff_mask;
                                at_line_start_next = stuff_line_start;
                            end
                        end
                        PH_HEADER: begin
                            if (bytes_left_reg != '0) begin
                                bytes_left_next = bytes_left_reg - SIZE_ONE;
                                if (at_line_start_reg && (data_byte == CH_LF)) begin
                                    // The blank line ends the header.
                                    phase_next      = PH_BODY;
                                    mask[SLOT_CR_A] = 1'b1;
                                    mask[SLOT_LF_A] = 1'b1;
                                end else begin
                                    mask               = stuff_mask;
                                    at_line_start_next = stuff_line_start;
                                end
                            end
                        end
                        PH_BODY: begin
                            if ((bytes_left_reg != '0) && (lines_left_reg != '0)) begin
                                bytes_left_next = bytes_left_reg - SIZE_ONE;
                                if (data_byte == CH_LF) begin
                                    lines_left_next = lines_left_reg - LINE_ONE;
                                end
                                mask               = stuff_mask;
                                at_line_start_next = stuff_line_start;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            REQ_FINISH: begin
                phase_next = PH_IDLE;
                if (!aborted_reg && (phase_reg != PH_IDLE)) begin
                    if ((phase_reg == PH_WHOLE) && (bytes_left_reg != '0)) begin
                        // Too few bytes arrived.
                        aborted_next     = 1'b1;
                        mask[SLOT_ABORT] = 1'b1;
                    end else begin
                        if (phase_reg == PH_WHOLE) begin
                            mask[SLOT_CR_A] = no_final_lf_reg;
                            mask[SLOT_LF_A] = no_final_lf_reg;
                        end else begin
                            if (phase_reg == PH_HEADER) begin
                                mask[SLOT_CR_A] = 1'b1;
                                mask[SLOT_LF_A] = 1'b1;
                            end
                            if ((bytes_left_reg == '0) && no_final_lf_reg) begin
                                mask[SLOT_CR_B] = 1'b1;
                                mask[SLOT_LF_B] = 1'b1;
                            end
                        end
                        mask[SLOT_TDOT] = 1'b1;
                        mask[SLOT_TCR]  = 1'b1;
                        mask[SLOT_TLF]  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Transfer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_line_start_reg <= 1'b1;
            phase_reg         <= PH_IDLE;
            bytes_left_reg    <= '0;
            lines_left_reg    <= '0;
            aborted_reg       <= 1'b0;
        end else if (accept) begin
            at_line_start_reg <= at_line_start_next;
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            lines_left_reg    <= lines_left_next;
            aborted_reg       <= aborted_next;
        end
    end

    // Only requests that send something enter the queue.
    assign push.push     = accept && (mask != '0);
    assign push.cmd.mask = mask;
    assign push.cmd.data = data_byte;

endmodule

// ===== src/mts_queue.sv =====
// Short command queue between the front and back parts.
// Register array with read and write pointers; uses mts_pkg.
module mts_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  mts_pkg::mts_push_t  push,
    input  logic                pop,
    output mts_pkg::mts_head_t  head,
    output logic                full
);
    import mts_pkg::*;

    mts_cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic                  do_pop;

    assign full       = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push.push) begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push.push && !do_pop) begin
                count_reg <= count_reg + (QUEUE_AW + 1)'(1);
            end else if (do_pop && !push.push) begin
                count_reg <= count_reg - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

// ===== src/mts_back.sv =====
// Back part: walks the slot mask of each command and sends one byte a cycle while m_ready allows.
// Holds the current command and the output register; uses mts_pkg.
module mts_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  mts_pkg::mts_head_t  head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_status,
    output logic                m_last
);
    import mts_pkg::*;

    slot_mask_t  cur_mask_reg, cur_mask_next;
    logic [7:0]  cur_data_reg;
    logic        m_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        status_reg;
    logic        last_reg;

    slot_mask_t  sel;
    slot_mask_t  rest;
    logic [7:0]  sel_byte;
    logic        out_free;
    logic        emit;
    logic        cur_done;

    // Byte that each slot sends.
    function automatic logic [7:0] slot_byte(input int unsigned slot, input logic [7:0] data);
        logic [7:0] value;
        case (slot)
            SLOT_ABORT: value = 8'h00;
            SLOT_DOT:   value = CH_DOT;
            SLOT_BYTE:  value = data;
            SLOT_CR_A:  value = CH_CR;
            SLOT_LF_A:  value = CH_LF;
            SLOT_CR_B:  value = CH_CR;
            SLOT_LF_B:  value = CH_LF;
            SLOT_TDOT:  value = CH_DOT;
            SLOT_TCR:   value = CH_CR;
            SLOT_TLF:   value = CH_LF;
            default:    value = 8'h00;
        endcase
        return value;
    endfunction

    // Lowest pending slot and the byte it sends.
    always_comb begin
        sel      = cur_mask_reg & (~cur_mask_reg + SLOT_COUNT'(1));
        rest     = cur_mask_reg & ~sel;
        sel_byte = 8'h00;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (sel[i]) begin
                sel_byte = sel_byte | slot_byte(i, cur_data_reg);
            end
        end
    end

    // Handshake between current command, queue and output register.
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = out_free && (cur_mask_reg != '0);
    assign cur_done = (cur_mask_reg == '0) || (emit && (rest == '0));
    assign pop      = cur_done && head.valid;

    always_comb begin
        cur_mask_next = cur_mask_reg;
        if (pop) begin
            cur_mask_next = head.cmd.mask;
        end else if (emit) begin
            cur_mask_next = rest;
        end
    end

    // Current command.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mask_reg <= '0;
        end else begin
            cur_mask_reg <= cur_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_data_reg <= head.cmd.data;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_byte_reg <= sel_byte;
            status_reg   <= sel[SLOT_ABORT];
            last_reg     <= (rest == '0);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_status   = status_reg;
    assign m_last     = last_reg;

endmodule

// ===== src/mail_transmit_dot_stuffer.sv =====
// Top level of the mail transmit dot stuffer: front, command queue and back.
// Depends on mts_pkg, mts_front, mts_queue and mts_back.
//
//  Channel   Ports                                   Direction  Transfer
//  request   s_valid s_ready s_req_type s_data_byte  in         valid/ready
//  result    m_valid m_ready m_out_byte m_status     out        valid/ready
//            m_last
//  config    cfg_we cfg_index cfg_wdata              in         write enable
//
// The front takes one request a cycle while the four-entry queue has room.
// The back sends one byte a cycle while m_ready allows, and a queued request
// causes one to seven bytes; a data byte that expands stalls the front only once
// the queue fills. A result passes the queue entry and the output register.
// Reset is synchronous and clears control state only; no clearing pass.
module mail_transmit_dot_stuffer #(
    parameter int SIZE_BITS = mts_pkg::MTS_SIZE_BITS,
    parameter int LINE_BITS = mts_pkg::MTS_LINE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mts_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mts_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_req_type,
    input  logic [7:0]                          s_data_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_status,
    output logic                                m_last
);
    import mts_pkg::*;

    mts_push_t  push;
    mts_head_t  head;
    logic       q_full;
    logic       q_pop;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Front: state and classification.
    mts_front #(
        .SIZE_BITS(SIZE_BITS),
        .LINE_BITS(LINE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .req_type  (s_req_type),
        .data_byte (s_data_byte),
        .push      (push)
    );

    // Command queue.
    mts_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (q_pop),
        .head    (head),
        .full    (q_full)
    );

    // Back: byte sequencing and output register.
    mts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_status   (m_status),
        .m_last     (m_last)
    );

`ifndef SYNTH
    // An abort result is always the only and final result of its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> m_last)
        else $error("abort result without last");

    // An abort result carries a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_out_byte == 8'h00))
        else $error("abort result with nonzero byte");

    // The front never writes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push.push)
        else $error("push into full queue");
`endif

endmodule

// ===== verif/mail_transmit_dot_stuffer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mail_transmit_dot_stuffer: directed and random messages
// against a cycle-free predictor of the stuffed transmit stream.
// Depends on mts_pkg and the mail_transmit_dot_stuffer RTL.
module mail_transmit_dot_stuffer_tb;
    import mts_pkg::*;

    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 330;
    localparam int unsigned SETTLE_LEN   = 32;
    localparam int unsigned HOLD_LEN     = 100;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // One byte of the transmit stream as the block should send it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       status;
        logic       last;
    } tx_byte_t;

    // Predicts the transmit stream for each accepted request and checks
    // the bytes that come out against it, oldest first.
    class tx_stream_board;
        tx_byte_t    due_bytes[$];
        tx_byte_t    fresh[$];
        int unsigned mismatches;
        int unsigned seen;

        bit          xfer_mode;
        logic [15:0] top_lines;
        logic [31:0] msg_size;
        bit          no_final_lf;

        bit          at_line_start;
        phase_t      phase;
        logic [31:0] bytes_left;
        logic [15:0] lines_left;
        bit          aborted;

        function new();
            xfer_mode     = 1'b0;
            top_lines     = '0;
            msg_size      = '0;
            no_final_lf   = 1'b0;
            at_line_start = 1'b1;
            phase         = PH_IDLE;
            bytes_left    = '0;
            lines_left    = '0;
            aborted       = 1'b0;
            mismatches    = 0;
            seen          = 0;
        endfunction

        function void report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endfunction

        // Register writes keep only the bits the register holds.
        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
            case (idx)
                REG_XFER_MODE:   xfer_mode   = val[0];
                REG_TOP_LINES:   top_lines   = val[15:0];
                REG_MSG_SIZE:    msg_size    = val;
                REG_NO_FINAL_LF: no_final_lf = val[0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic st);
            tx_byte_t t;
            t.out_byte = b;
            t.status   = st;
            t.last     = 1'b0;
            fresh.push_back(t);
        endfunction

        function void push_crlf();
            push_byte(CH_CR, 1'b0);
            push_byte(CH_LF, 1'b0);
        endfunction

        // A dot at line start is doubled and LF goes out as CR LF.
        function void stuff_byte(logic [7:0] b);
            if (at_line_start && b == CH_DOT) push_byte(CH_DOT, 1'b0);
            if (b == CH_LF) begin
                push_crlf();
                at_line_start = 1'b1;
            end else begin
                push_byte(b, 1'b0);
                at_line_start = 1'b0;
            end
        endfunction

        // Works out the bytes caused by one accepted request.
        function void stuff_request(logic [1:0] kind, logic [7:0] b);
            fresh.delete();
            case (kind)
                REQ_START: begin
                    // The phantom newline is not among the stored bytes.
                    bytes_left    = (no_final_lf && msg_size != 0) ? msg_size - 1 : msg_size;
                    lines_left    = top_lines;
                    at_line_start = 1'b1;
                    aborted       = 1'b0;
                    phase         = xfer_mode ? PH_HEADER : PH_WHOLE;
                end
                REQ_DATA: begin
                    if (phase != PH_IDLE && !aborted) begin
                        case (phase)
                            PH_WHOLE: begin
                                if (bytes_left == 0) begin
                                    // More bytes than the stored size.
                                    aborted = 1'b1;
                                    push_byte(8'h00, 1'b1);
                                end else begin
                                    bytes_left = bytes_left - 1;
                                    stuff_byte(b);
                                end
                            end
                            PH_HEADER: begin
                                if (bytes_left != 0) begin
                                    bytes_left = bytes_left - 1;
                                    if (at_line_start && b == CH_LF) begin
                                        // Blank line closes the header.
                                        phase = PH_BODY;
                                        push_crlf();
                                    end else begin
                                        stuff_byte(b);
                                    end
                                end
                            end
                            default: begin
                                if (bytes_left != 0 && lines_left != 0) begin
                                    bytes_left = bytes_left - 1;
                                    if (b == CH_LF) lines_left = lines_left - 1;
                                    stuff_byte(b);
                                end
                            end
                        endcase
                    end
                end
                REQ_FINISH: begin
                    if (phase == PH_WHOLE && !aborted && bytes_left != 0) begin
                        // Fewer bytes than the stored size.
                        aborted = 1'b1;
                        push_byte(8'h00, 1'b1);
                    end else if (phase != PH_IDLE && !aborted) begin
                        if (phase == PH_WHOLE) begin
                            if (no_final_lf) push_crlf();
                        end else begin
                            if (phase == PH_HEADER) push_crlf();
                            if (bytes_left == 0 && no_final_lf) push_crlf();
                        end
                        push_byte(CH_DOT, 1'b0);
                        push_crlf();
                    end
                    phase = PH_IDLE;
                end
                default: ;
            endcase
            if (fresh.size() != 0) fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[i]) due_bytes.push_back(fresh[i]);
        endfunction

        // Compares one received byte with the oldest expected one.
        function void check_byte(logic [7:0] b, logic st, logic lst);
            tx_byte_t want;
            seen++;
            if (due_bytes.size() == 0) begin
                report_mismatch($sformatf("result %0d unexpected: byte %02h status %0b last %0b",
                                          seen, b, st, lst));
                return;
            end
            want = due_bytes.pop_front();
            if (b !== want.out_byte)
                report_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                          seen, b, want.out_byte));
            if (st !== want.status)
                report_mismatch($sformatf("result %0d status %0b, expected %0b",
                                          seen, st, want.status));
            if (lst !== want.last)
                report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                          seen, lst, want.last));
        endfunction
    endclass

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_we      = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata   = '0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_req_type  = REQ_START;
    logic [7:0]                s_data_byte = 8'h00;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic [7:0]                m_out_byte;
    logic                      m_status;
    logic                      m_last;

    tx_stream_board sb = new();
    int unsigned    cyc          = 0;
    int unsigned    burst_left   = 0;
    int unsigned    msg_items    = 0;
    bit             gaps_on      = 1'b0;
    bit             hold_request = 1'b0;

    mail_transmit_dot_stuffer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_status    (m_status),
        .m_last      (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Cycle count for the receiver pattern and the run limit.
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("mail_transmit_dot_stuffer_tb failed");
            $finish;
        end
    end

    // Receiver: checks each accepted byte and stalls on a pattern chosen from four
    // by the cycle count, or holds off entirely when asked.
    initial begin : receiver
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_byte(m_out_byte, m_status, m_last);
            if (hold_request) begin
                hold_request = 1'b0;
                hold = HOLD_LEN;
            end
            if (hold != 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                case ((cyc / 200) % 4)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom);
                    2: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ((cyc % 5) < 3);
                endcase
            end
        end
    end

    // Offers one request and returns at the edge where it is accepted.
    // With gaps on, requests go out in bursts separated by idle stretches.
    task automatic send_req(input logic [1:0] kind, input logic [7:0] value);
        int unsigned gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid     <= 1'b0;
            s_req_type  <= 2'($urandom);
            s_data_byte <= 8'($urandom);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left != 0) burst_left--;
        s_valid     <= 1'b1;
        s_req_type  <= kind;
        s_data_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.stuff_request(kind, value);
    endtask

    // Waits until every expected byte has come, then lets requests that
    // cause no output work their way through.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.due_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_LEN) @(posedge aclk);
    endtask

    // Writes all four registers; unused upper bits carry random values.
    task automatic load_config(input bit mode, input logic [15:0] lines,
                               input logic [31:0] msg_len, input bit eol);
        logic [CFG_INDEX_BITS-1:0] regs [4];
        logic [31:0]               vals [4];
        regs = '{REG_XFER_MODE, REG_TOP_LINES, REG_MSG_SIZE, REG_NO_FINAL_LF};
        vals = '{{31'($urandom), mode}, {16'($urandom), lines}, msg_len, {31'($urandom), eol}};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.write_reg(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // One random message: lines rich in leading dots and blank lines, a
    // size that mostly matches, and now and then a broken sequence.
    task automatic run_message(input bit busy);
        logic [7:0]  text[$];
        logic [7:0]  c;
        int unsigned n_lines, len, flaw, pos;
        bit          mode, eol;
        logic [15:0] lines;
        logic [31:0] msg_len;
        mode    = 1'($urandom);
        eol     = ($urandom_range(0, 2) == 0);
        n_lines = busy ? 8 : $urandom_range(0, 6);
        for (int l = 0; l < n_lines; l++) begin
            len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 5))
                    0, 1: c = CH_DOT;
                    2: c = 8'($urandom_range(8'h61, 8'h7A));
                    default: c = 8'($urandom);
                endcase
                text.push_back(c);
            end
            text.push_back(CH_LF);
        end
        if (eol && text.size() != 0 && text[text.size()-1] == CH_LF) void'(text.pop_back());
        msg_len = text.size() + eol;
        case ($urandom_range(0, 11))
            0: msg_len = msg_len + $urandom_range(1, 3);
            1: msg_len = (msg_len > 3) ? msg_len - $urandom_range(1, 3) : 32'd0;
            2: msg_len = 32'hFFFF_FFFF;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: lines = 16'h0000;
            1: lines = 16'hFFFF;
            2: lines = 16'($urandom);
            default: lines = 16'($urandom_range(1, 4));
        endcase
        // Flaws: no start, restart midway, early finish, stray bytes after finish.
        flaw = busy ? 99 : $urandom_range(0, 19);
        pos  = $urandom_range(0, text.size());

        drain();
        load_config(mode, lines, msg_len, eol);
        gaps_on = !busy && ($urandom_range(0, 3) != 0);
        if (busy) hold_request = 1'b1;
        if (flaw != 0) send_req(REQ_START, 8'($urandom));
        for (int i = 0; i < text.size(); i++) begin
            if (i == pos && flaw == 1) send_req(REQ_START, 8'($urandom));
            if (i == pos && flaw == 2) send_req(REQ_FINISH, 8'($urandom));
            if ($urandom_range(0, 24) == 0) send_req(REQ_UNUSED, 8'($urandom));
            send_req(REQ_DATA, text[i]);
        end
        send_req(REQ_FINISH, 8'($urandom));
        if (flaw == 3) begin
            send_req(REQ_DATA, 8'($urandom));
            send_req(REQ_FINISH, 8'($urandom));
        end
        msg_items += text.size() + 2;
    endtask

    initial begin : stimulus
        int unsigned msg_no;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle block: data, finish and the unused code give nothing.
        send_req(REQ_DATA, 8'hFF);
        send_req(REQ_FINISH, 8'h00);
        send_req(REQ_UNUSED, 8'hAA);

        // Whole message with dots at line start and an LF inside.
        drain();
        load_config(1'b0, 16'h0000, 32'd4, 1'b0);
        send_req(REQ_START, 8'h00);
        send_req(REQ_DATA, CH_DOT);
        send_req(REQ_DATA, 8'h00);
        send_req(REQ_DATA, CH_LF);
        send_req(REQ_DATA, CH_DOT);
        send_req(REQ_FINISH, 8'hFF);

        // Zero size with missing EOL saturates, so the first byte overruns.
        drain();
        load_config(1'b0, 16'hFFFF, 32'd0, 1'b1);
        send_req(REQ_START, 8'h00);
        send_req(REQ_DATA, 8'h78);
        send_req(REQ_DATA, 8'h79);
        send_req(REQ_FINISH, 8'h00);

        // Restart mid-transfer, then a phantom newline at finish.
        drain();
        load_config(1'b0, 16'h0000, 32'd2, 1'b1);
        send_req(REQ_START, 8'h00);
        send_req(REQ_DATA, 8'h61);
        send_req(REQ_START, 8'h00);
        send_req(REQ_DATA, 8'h62);
        send_req(REQ_FINISH, 8'h00);

        // Finish with a byte still owed.
        send_req(REQ_START, 8'h00);
        send_req(REQ_FINISH, 8'h00);

        // Header, blank line, one body line, then a dropped byte.
        drain();
        load_config(1'b1, 16'd1, 32'hFFFF_FFFF, 1'b1);
        send_req(REQ_START, 8'h00);
        send_req(REQ_DATA, 8'h68);
        send_req(REQ_DATA, CH_LF);
        send_req(REQ_DATA, CH_LF);
        send_req(REQ_DATA, CH_DOT);
        send_req(REQ_DATA, CH_LF);
        send_req(REQ_DATA, 8'h7A);
        send_req(REQ_FINISH, 8'h00);

        // Random messages; two of them run under a long receiver hold-off.
        msg_no = 0;
        while (msg_items < RANDOM_ITEMS) begin
            run_message(msg_no == 2 || msg_no == 17);
            msg_no++;
        end

        drain();
        if (sb.due_bytes.size() != 0)
            sb.report_mismatch($sformatf("%0d expected bytes never arrived", sb.due_bytes.size()));
        if (sb.mismatches == 0) begin
            $display("mail_transmit_dot_stuffer_tb passed");
        end else begin
            $display("mail_transmit_dot_stuffer_tb failed");
        end
        $finish;
    end
endmodule
